[rtl/ats_pkg.sv]
// ----------------------------------------------------------------------------
// ats_pkg: shared types and constants of the text-to-integer converter
// Holds the parse phase type, the character and radix codes, and the
// command and status records that pass between controller and datapath.
// ----------------------------------------------------------------------------
package ats_pkg;

  typedef enum logic [2:0] {
    PH_SPACE  = 3'd0,
    PH_START  = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  // Register indexes on the configuration port.
  localparam logic REG_NUMBER_BASE  = 1'b0;
  localparam logic REG_ALLOW_BINARY = 1'b1;

  // Radix codes.
  localparam logic [5:0] BASE_AUTO    = 6'd0;
  localparam logic [5:0] BASE_ONE     = 6'd1;
  localparam logic [5:0] BASE_BIN     = 6'd2;
  localparam logic [5:0] BASE_OCT     = 6'd8;
  localparam logic [5:0] BASE_DEC     = 6'd10;
  localparam logic [5:0] BASE_HEX     = 6'd16;
  localparam logic [5:0] BASE_MAX     = 6'd36;
  localparam logic [5:0] BASE_RESET   = BASE_DEC;
  localparam logic [5:0] NOT_A_DIGIT  = 6'd63;

  // Character codes.
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
  localparam logic [7:0] CH_UPPER_B   = 8'h42;
  localparam logic [7:0] CH_LOWER_B   = 8'h62;
  localparam logic [7:0] CH_UPPER_X   = 8'h58;
  localparam logic [7:0] CH_LOWER_X   = 8'h78;
  localparam logic [7:0] CASE_BIT     = 8'h20;
  localparam logic [7:0] LETTER_BIAS  = 8'h37;  // 'A' - 10

  // Controller to datapath.
  typedef struct packed {
    logic       step;       // a word is accepted this cycle
    logic       take;       // accumulate the current digit
    logic       load_base;  // store base as the working base
    logic [5:0] base;       // radix in force for this word
    logic       set_neg;    // a minus sign was seen
    logic       clear;      // end of string: return to the reset state
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [5:0] digit;      // digit value of the character, or NOT_A_DIGIT
    logic       space;
    logic       plus;
    logic       minus;
    logic       zero;
    logic       x_char;
    logic       b_char;
    logic [5:0] wbase;      // stored working base
  } status_t;

endpackage

[rtl/ats_ctrl.sv]
// ----------------------------------------------------------------------------
// ats_ctrl: parse sequencer
// Walks through white space, sign, radix prefix and digits, and tells the
// datapath which radix is in force and whether to take the digit.
// ----------------------------------------------------------------------------
module ats_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               last,
  input  logic [5:0]         cfg_base,
  input  logic               cfg_bin,
  input  ats_pkg::status_t   st,
  output ats_pkg::cmd_t      cmd
);
  import ats_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [5:0] wb_in;
  logic       sn_pfx;
  logic [5:0] sn_base;
  logic       sn_ok;
  logic       tk_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SPACE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // Radix and prefix decisions for the first character of the number.
  always_comb begin
    wb_in   = (phase_r == PH_SPACE) ? cfg_base : st.wbase;
    sn_pfx  = st.zero && (wb_in == BASE_AUTO || wb_in == BASE_HEX ||
                          (wb_in == BASE_BIN && cfg_bin));
    if (wb_in == BASE_AUTO) begin
      sn_base = sn_pfx ? BASE_OCT : BASE_DEC;
    end else begin
      sn_base = wb_in;
    end
    sn_ok = (sn_base >= BASE_BIN) && (st.digit < sn_base);
    tk_ok = (st.wbase >= BASE_BIN) && (st.digit < st.wbase);
  end

  always_comb begin
    phase_nxt     = phase_r;
    cmd.step      = step;
    cmd.take      = 1'b0;
    cmd.load_base = 1'b0;
    cmd.base      = st.wbase;
    cmd.set_neg   = 1'b0;
    cmd.clear     = 1'b0;
    if (step) begin
      case (phase_r)
        PH_SPACE, PH_START: begin
          if (phase_r == PH_START || !st.space) begin
            cmd.load_base = 1'b1;
            if (phase_r == PH_SPACE &&
                (cfg_base == BASE_ONE || cfg_base > BASE_MAX)) begin
              cmd.base  = cfg_base;
              phase_nxt = PH_DONE;
            end else if (phase_r == PH_SPACE && st.minus) begin
              cmd.base    = cfg_base;
              cmd.set_neg = 1'b1;
              phase_nxt   = PH_START;
            end else if (phase_r == PH_SPACE && st.plus) begin
              cmd.base  = cfg_base;
              phase_nxt = PH_START;
            end else begin
              cmd.base = sn_base;
              if (sn_pfx) begin
                cmd.take  = 1'b1;
                phase_nxt = PH_ZERO;
              end else if (sn_ok) begin
                cmd.take  = 1'b1;
                phase_nxt = PH_DIGITS;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
          end
        end
        PH_ZERO: begin
          if (st.x_char && (st.wbase == BASE_OCT || st.wbase == BASE_HEX)) begin
            cmd.load_base = 1'b1;
            cmd.base      = BASE_HEX;
            phase_nxt     = PH_DIGITS;
          end else if (st.b_char && cfg_bin &&
                       (st.wbase == BASE_OCT || st.wbase == BASE_BIN)) begin
            cmd.load_base = 1'b1;
            cmd.base      = BASE_BIN;
            phase_nxt     = PH_DIGITS;
          end else if (tk_ok) begin
            cmd.take  = 1'b1;
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (tk_ok) begin
            cmd.take = 1'b1;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
      if (last) begin
        phase_nxt = PH_SPACE;
        cmd.clear = 1'b1;
      end
    end
  end

endmodule

[rtl/ats_dp.sv]
// ----------------------------------------------------------------------------
// ats_dp: conversion datapath
// Decodes characters, multiplies and accumulates the magnitude with its
// saturation check, tracks positions, and forms the result fields.
// ----------------------------------------------------------------------------
module ats_dp #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_OFFSET  = 1023,
  parameter int OFS_W       = $clog2(MAX_OFFSET + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [7:0]                    ch,
  input  ats_pkg::cmd_t                 cmd,
  output ats_pkg::status_t              st,
  output logic signed [VALUE_WIDTH-1:0] res_value,
  output logic                          res_range_error,
  output logic [OFS_W-1:0]              res_end_offset,
  output logic                          res_any_converted
);
  import ats_pkg::*;

  localparam int PW = VALUE_WIDTH + 6;
  localparam logic [VALUE_WIDTH-1:0] HALF = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [OFS_W-1:0] MAX_OFS = OFS_W'(MAX_OFFSET);

  logic                   neg_r, neg_nxt;
  logic [5:0]             wbase_r, wbase_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   taken_r, taken_nxt;
  logic [OFS_W-1:0]       pos_r, pos_nxt;
  logic [OFS_W-1:0]       stop_r, stop_nxt;
  logic [OFS_W-1:0]       pos_inc;
  logic [PW-1:0]          prod;
  logic [PW-1:0]          lim;
  logic [7:0]             upper;

  // Character decode.
  always_comb begin
    upper = ch & ~CASE_BIT;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      st.digit = 6'(ch - CH_ZERO);
    end else if ((ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ||
                 (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)) begin
      st.digit = 6'(upper - LETTER_BIAS);
    end else begin
      st.digit = NOT_A_DIGIT;
    end
    st.space  = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    st.plus   = (ch == CH_PLUS);
    st.minus  = (ch == CH_MINUS);
    st.zero   = (ch == CH_ZERO);
    st.x_char = (ch == CH_LOWER_X) || (ch == CH_UPPER_X);
    st.b_char = (ch == CH_LOWER_B) || (ch == CH_UPPER_B);
    st.wbase  = wbase_r;
  end

  // Multiply-accumulate; acc * base + d > limit is the same test as
  // acc > (limit - d) / base for the integer quotient.
  always_comb begin
    prod = {6'd0, acc_r} * {{VALUE_WIDTH{1'b0}}, cmd.base} + {{(PW-6){1'b0}}, st.digit};
    lim  = {6'd0, HALF} - (neg_r ? {PW{1'b0}} : {{(PW-1){1'b0}}, 1'b1});
    pos_inc = (pos_r < MAX_OFS) ? pos_r + 1'b1 : pos_r;
  end

  always_comb begin
    neg_nxt   = neg_r;
    wbase_nxt = wbase_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    taken_nxt = taken_r;
    pos_nxt   = pos_r;
    stop_nxt  = stop_r;
    if (cmd.step) begin
      pos_nxt = pos_inc;
      if (cmd.set_neg) begin
        neg_nxt = 1'b1;
      end
      if (cmd.load_base) begin
        wbase_nxt = cmd.base;
      end
      if (cmd.take) begin
        if (ovf_r || prod > lim) begin
          ovf_nxt = 1'b1;
          acc_nxt = lim[VALUE_WIDTH-1:0];
        end else begin
          acc_nxt = prod[VALUE_WIDTH-1:0];
        end
        taken_nxt = 1'b1;
        stop_nxt  = pos_inc;
      end
    end
  end

  // The result reflects the state after the last character has been parsed.
  always_comb begin
    if (taken_nxt) begin
      res_value         = neg_nxt ? $signed(~acc_nxt + 1'b1) : $signed(acc_nxt);
      res_range_error   = ovf_nxt;
      res_end_offset    = stop_nxt;
      res_any_converted = 1'b1;
    end else begin
      res_value         = '0;
      res_range_error   = 1'b0;
      res_end_offset    = '0;
      res_any_converted = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      neg_r   <= 1'b0;
      wbase_r <= BASE_AUTO;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      taken_r <= 1'b0;
      pos_r   <= '0;
      stop_r  <= '0;
    end else begin
      neg_r   <= neg_nxt;
      wbase_r <= wbase_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      taken_r <= taken_nxt;
      pos_r   <= pos_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

[rtl/ascii_to_signed_integer.sv]
// ----------------------------------------------------------------------------
// ascii_to_signed_integer: streaming text-to-integer converter
// Parses one character per word in the style of strtol and returns the
// signed value, a range error flag and the end offset on the last word.
// ----------------------------------------------------------------------------
// While in_tready is high the block takes one character per cycle: every
// input word is parsed in the cycle in which it is accepted, by a single
// multiply-accumulate of the magnitude with its saturation compare.
// Leading white space is skipped, an optional sign is taken, then an optional
// 0, 0x or 0b prefix and digits in bases 2 to 36; parsing stops at the first
// character that is not a digit and the rest of the string is ignored. On the
// word with tlast set, one result word is produced and the parser returns to
// its reset state. The result waits in an output register; a new character is
// accepted whenever that register is empty or is being emptied in the same
// cycle. Configuration is written through the APB-style port while the block
// is idle: register 0 (byte address 0) is the number base, 0 selecting the
// base from the prefix, and register 1 (byte address 4) enables the 0b prefix.
// ----------------------------------------------------------------------------
module ascii_to_signed_integer #(
  parameter int  VALUE_WIDTH = 32,
  parameter int  MAX_OFFSET  = 1023,
  localparam int OFS_W       = $clog2(MAX_OFFSET + 1),
  localparam int OUT_W       = ((VALUE_WIDTH + OFS_W + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  // input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,      // [7:0] ch
  input  logic             in_tlast,
  // result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,     // value, range_error, end_offset,
                                          // any_converted, zero fill
  // configuration port
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import ats_pkg::*;

  logic [5:0]                    base_r;
  logic                          bin_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]              out_data_r;
  logic                          step;
  logic                          cfg_wr;
  logic                          reg_idx;
  cmd_t                          cmd;
  status_t                       st;
  logic signed [VALUE_WIDTH-1:0] res_value;
  logic                          res_range_error;
  logic [OFS_W-1:0]              res_end_offset;
  logic                          res_any_converted;

  // A word is accepted when the output register is free or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
      bin_r  <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_NUMBER_BASE:  base_r <= cfg_pwdata[5:0];
        REG_ALLOW_BINARY: bin_r  <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NUMBER_BASE:  cfg_prdata = {26'd0, base_r};
      REG_ALLOW_BINARY: cfg_prdata = {31'd0, bin_r};
      default:          cfg_prdata = '0;
    endcase
  end

  ats_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .last     (in_tlast),
    .cfg_base (base_r),
    .cfg_bin  (bin_r),
    .st       (st),
    .cmd      (cmd)
  );

  ats_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_OFFSET  (MAX_OFFSET),
    .OFS_W       (OFS_W)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ch                (in_tdata),
    .cmd               (cmd),
    .st                (st),
    .res_value         (res_value),
    .res_range_error   (res_range_error),
    .res_end_offset    (res_end_offset),
    .res_any_converted (res_any_converted)
  );

  // Output register: loaded by the last character of a string.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (step && in_tlast) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // The fields are packed from the lowest bit up and zero-extended to bytes.
  always_ff @(posedge clk) begin
    if (step && in_tlast) begin
      out_data_r <= OUT_W'({res_any_converted, res_end_offset, res_range_error,
                            res_value});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[sim/ascii_to_signed_integer_test.sv]
// ----------------------------------------------------------------------------
// ascii_to_signed_integer_test: self-checking bench for the text converter
// Streams character words into the converter, forecasts every result word
// with a cycle-free model of the parser, and compares what comes back field
// by field, under random idling on both channels and several radix settings.
// ----------------------------------------------------------------------------
module ascii_to_signed_integer_test;
  import ats_pkg::*;

  localparam int          OUT_BITS   = 48;
  localparam logic [9:0]  OFFSET_TOP = 10'd1023;
  localparam int          SHOW_LIMIT = 10;
  // Generous bound on the whole run, in clock cycles.
  localparam int          RUN_CYCLES = 200000;

  // One result word, unpacked from out_tdata.
  typedef struct packed {
    logic signed [31:0] value;
    logic               range_err;
    logic [9:0]         end_ofs;
    logic               converted;
  } conv_result_t;

  // A directed string: everything but its final character, then the final
  // character as a byte so that a NUL can end a string too.
  typedef struct {
    logic [5:0]   base;
    string        head;
    logic [7:0]   tail;
    bit           typed;
    conv_result_t want;
  } dir_row_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata    = 8'h00;
  logic                in_tlast    = 1'b0;
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [2:0]          cfg_paddr   = 3'd0;
  logic [31:0]         cfg_pwdata  = 32'd0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  ascii_to_signed_integer u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),      // [7:0] ch
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),     // [31:0] value, [32] range_error,
                                  // [42:33] end_offset, [43] any_converted
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Results forecast for accepted last words, oldest first.
  conv_result_t pending_results[$];
  int           fault_count = 0;

  // Idling percentages of the two sides, and a request for one long stall
  // of the receiver.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request  = 1'b0;

  // The characters of the string being sent.
  logic [7:0] text_q[$];

  // --------------------------------------------------------------------------
  // Parser model. The register copies follow every configuration write; the
  // parse state follows every accepted character word.
  // --------------------------------------------------------------------------
  logic [5:0]        radix_reg  = BASE_RESET;
  logic              binary_ok  = 1'b1;
  phase_t            m_phase    = PH_SPACE;
  logic              m_neg      = 1'b0;
  logic [5:0]        m_base     = BASE_AUTO;
  longint unsigned   m_mag      = 0;
  logic              m_ovf      = 1'b0;
  logic              m_taken    = 1'b0;
  logic [9:0]        m_pos      = 10'd0;
  logic [9:0]        m_stop     = 10'd0;

  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [7:0] up;
    up = c & ~CASE_BIT;
    if (c >= CH_ZERO && c <= CH_NINE) return 6'(c - CH_ZERO);
    if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z))
      return 6'(up - LETTER_BIAS);
    return NOT_A_DIGIT;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Take c as a digit of the working radix, or end the number here. The
  // magnitude saturates at the limit of the sign in force.
  function automatic void add_digit(input logic [7:0] c);
    logic [5:0]      d;
    longint unsigned lim;
    d = digit_value(c);
    if (m_base < BASE_BIN || d >= m_base) begin
      m_phase = PH_DONE;
      return;
    end
    lim = (64'd1 << 31) - (m_neg ? 64'd0 : 64'd1);
    if (m_ovf || m_mag > (lim - d) / m_base) begin
      m_ovf = 1'b1;
      m_mag = lim;
    end else begin
      m_mag = m_mag * m_base + d;
    end
    m_taken = 1'b1;
    m_stop  = (m_pos + 11'd1 > OFFSET_TOP) ? OFFSET_TOP : m_pos + 10'd1;
    m_phase = PH_DIGITS;
  endfunction

  // First character of the number proper: a leading zero may open a prefix.
  function automatic void open_number(input logic [7:0] c);
    if (c == CH_ZERO && (m_base == BASE_AUTO || m_base == BASE_HEX ||
                         (m_base == BASE_BIN && binary_ok))) begin
      if (m_base == BASE_AUTO) m_base = BASE_OCT;
      add_digit(c);
      m_phase = PH_ZERO;
      return;
    end
    if (m_base == BASE_AUTO) m_base = BASE_DEC;
    add_digit(c);
  endfunction

  // Advance the model by one character word; returns 1 with the forecast
  // result when the word closes the string.
  function automatic bit convert_char(input logic [7:0] c, input bit last,
                                      output conv_result_t r);
    logic [31:0] mag32;
    r = '0;
    case (m_phase)
      PH_SPACE: begin
        if (!is_blank(c)) begin
          m_base = radix_reg;
          if (m_base == BASE_ONE || m_base > BASE_MAX) begin
            m_phase = PH_DONE;
          end else if (c == CH_MINUS) begin
            m_neg   = 1'b1;
            m_phase = PH_START;
          end else if (c == CH_PLUS) begin
            m_phase = PH_START;
          end else begin
            open_number(c);
          end
        end
      end
      PH_START: open_number(c);
      PH_ZERO: begin
        if ((c == CH_LOWER_X || c == CH_UPPER_X) &&
            (m_base == BASE_OCT || m_base == BASE_HEX)) begin
          m_base  = BASE_HEX;
          m_phase = PH_DIGITS;
        end else if ((c == CH_LOWER_B || c == CH_UPPER_B) && binary_ok &&
                     (m_base == BASE_OCT || m_base == BASE_BIN)) begin
          m_base  = BASE_BIN;
          m_phase = PH_DIGITS;
        end else begin
          add_digit(c);
        end
      end
      PH_DIGITS: add_digit(c);
      default:   m_phase = PH_DONE;
    endcase
    if (m_pos < OFFSET_TOP) m_pos = m_pos + 10'd1;
    if (!last) return 1'b0;
    if (m_taken) begin
      mag32       = m_mag[31:0];
      r.value     = m_neg ? -mag32 : mag32;
      r.range_err = m_ovf;
      r.end_ofs   = m_stop;
      r.converted = 1'b1;
    end
    // The string is closed: the parser returns to its reset state, the
    // registers keep their values.
    m_phase = PH_SPACE;
    m_neg   = 1'b0;
    m_base  = BASE_AUTO;
    m_mag   = 0;
    m_ovf   = 1'b0;
    m_taken = 1'b0;
    m_pos   = 10'd0;
    m_stop  = 10'd0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Failure reporting: every fault is counted, only the first few are shown.
  // --------------------------------------------------------------------------
  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= SHOW_LIMIT) $display("%s", msg);
  endtask

  // --------------------------------------------------------------------------
  // Sender. A word is put on the bus at a falling edge, after a random gap,
  // and counts as taken at the rising edge where tvalid and tready are both
  // high. tvalid stays high from one word to the next unless a gap follows.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] c, input bit last, input bit typed,
                           input conv_result_t want);
    conv_result_t fc;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (convert_char(c, last, fc)) pending_results.push_back(typed ? want : fc);
  endtask

  // Sends the string held in text_q, flagging its final character as last.
  task automatic send_text(inout int words);
    for (int i = 0; i < text_q.size(); i++) begin
      send_word(text_q[i], i == text_q.size() - 1, 1'b0, '0);
      words++;
    end
  endtask

  // Lowers tvalid and waits until every forecast result has come back, then
  // lets the clock run on so that the block is certainly idle.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Configuration port: an APB write, then a read of the same register to
  // confirm the value took. The model's copy follows the write.
  // --------------------------------------------------------------------------
  task automatic write_register(input logic idx, input logic [31:0] wdata);
    logic [31:0] mask;
    logic [31:0] rd;
    mask = (idx == REG_NUMBER_BASE) ? 32'h0000_003F : 32'h0000_0001;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == REG_NUMBER_BASE) radix_reg = wdata[5:0];
    else binary_ok = wdata[0];
    if ((rd & mask) !== (wdata & mask))
      note_fault($sformatf("register %0d read back %h, written %h", idx, rd, wdata));
  endtask

  // --------------------------------------------------------------------------
  // String generator. Most strings are well formed (blanks, a sign, a prefix,
  // digits of the radix in force, trailing junk); some are bare noise.
  // --------------------------------------------------------------------------
  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(d - 10);
  endfunction

  function automatic logic [7:0] blank_char();
    if ($urandom_range(0, 2) == 0) return CH_SPACE;
    return CH_TAB + 8'($urandom_range(0, 4));
  endfunction

  task automatic build_text();
    int              kind;
    int              p;
    int              db;
    int              n;
    bit              auto_mode;
    longint unsigned m;
    logic [7:0]      digs[$];
    text_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) text_q.push_back(blank_char());
    case ($urandom_range(0, 2))
      1: text_q.push_back(CH_PLUS);
      2: text_q.push_back(CH_MINUS);
      default: ;
    endcase
    auto_mode = radix_reg == BASE_AUTO;
    db = (radix_reg >= BASE_BIN && radix_reg <= BASE_MAX) ? int'(radix_reg) : 10;
    p  = $urandom_range(0, 3);
    if (!auto_mode && $urandom_range(0, 2) != 0) p = 0;
    if (p != 0) text_q.push_back(CH_ZERO);
    if (p == 1) text_q.push_back($urandom_range(0, 1) ? CH_UPPER_X : CH_LOWER_X);
    if (p == 2) text_q.push_back($urandom_range(0, 1) ? CH_UPPER_B : CH_LOWER_B);
    if (auto_mode) db = (p == 1) ? 16 : (p == 2) ? 2 : (p == 3) ? 8 : 10;
    if ($urandom_range(0, 9) == 0) begin
      // A magnitude right at the edge of the signed range.
      m = (64'd1 << 31) - 2 + $urandom_range(0, 3);
      do begin
        digs.push_front(digit_char(int'(m % db)));
        m = m / db;
      end while (m != 0);
      foreach (digs[i]) text_q.push_back(digs[i]);
    end else begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 34) : $urandom_range(0, 8);
      repeat (n) text_q.push_back(digit_char($urandom_range(0, db - 1)));
    end
    repeat ($urandom_range(0, 2)) text_q.push_back(8'($urandom_range(0, 255)));
    if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Receiver. tready changes at the falling edge. On request it is held low
  // for a long stretch, counted here, while the sender keeps offering words,
  // so the pending result blocks the input side.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result checker: each accepted result word against the oldest forecast.
  always @(posedge clk) begin
    conv_result_t got;
    conv_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.value     = out_tdata[31:0];
      got.range_err = out_tdata[32];
      got.end_ofs   = out_tdata[42:33];
      got.converted = out_tdata[43];
      if (pending_results.size() == 0) begin
        note_fault($sformatf("unexpected result: value %0d range_error %0b end_offset %0d %s %0b",
                             got.value, got.range_err, got.end_ofs, "any_converted",
                             got.converted));
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value || got.range_err !== want.range_err ||
            got.end_ofs !== want.end_ofs || got.converted !== want.converted)
          note_fault($sformatf({"result mismatch: expected value %0d range_error %0b ",
                                "end_offset %0d any_converted %0b, got value %0d ",
                                "range_error %0b end_offset %0d any_converted %0b"},
                               want.value, want.range_err, want.end_ofs, want.converted,
                               got.value, got.range_err, got.end_ofs, got.converted));
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(4 * RUN_CYCLES);
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus: a directed pass, then random strings in three idling regimes of
  // four radix settings each.
  // --------------------------------------------------------------------------
  initial begin
    dir_row_t   dir_rows[10];
    logic [5:0] set_base[12];
    logic       set_binary[12];
    logic [5:0] cur_base;
    int         words;
    int         k;

    // Rows with typed results can be read off directly; the rest go
    // through the model.
    dir_rows = '{
      // Straight after reset the radix is decimal.
      '{BASE_DEC, "",        "7",    1'b1, '{32'sd7, 1'b0, 10'd1, 1'b1}},
      // Blanks and a sign followed by a second sign: nothing converted.
      '{BASE_DEC, "\t\015-", CH_PLUS, 1'b1, '0},
      // Six top digits of radix 36 pass the positive limit.
      '{BASE_MAX, "zzzzz",   "z",    1'b1, '{32'sh7FFF_FFFF, 1'b1, 10'd6, 1'b1}},
      // And with a minus sign they pass the negative limit.
      '{BASE_MAX, "-ZZZZZ",  "Z",    1'b1, '{32'sh8000_0000, 1'b1, 10'd7, 1'b1}},
      // A hex prefix with no digit after it: only the zero counts.
      '{BASE_AUTO, "0",      "x",    1'b1, '{32'sd0, 1'b0, 10'd1, 1'b1}},
      // Prefixes are accepted in an explicit radix of 16 or 2.
      '{BASE_HEX, "0X",      "f",    1'b0, '0},
      '{BASE_BIN, "0b",      "1",    1'b0, '0},
      // A byte above the ASCII range ends the number.
      '{BASE_AUTO, "0b",     8'hFF,  1'b0, '0},
      // So does a NUL.
      '{BASE_AUTO, "",       8'h00,  1'b1, '0},
      // Radix one is not a radix at all.
      '{BASE_ONE, "",        "5",    1'b1, '0}
    };

    set_base   = '{BASE_AUTO, BASE_BIN, BASE_MAX, BASE_HEX, BASE_DEC, BASE_AUTO,
                   BASE_BIN, BASE_OCT, 6'd37, BASE_ONE, 6'd63, BASE_AUTO};
    set_binary = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    // The last setting is drawn at random over the whole register range.
    set_base[11]   = 6'($urandom_range(0, 63));
    set_binary[11] = 1'($urandom_range(0, 1));

    send_idle_pct = 15;
    recv_idle_pct = 60;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass. The radix is only rewritten when a row needs another.
    cur_base = BASE_RESET;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].base != cur_base) begin
        drain_results();
        write_register(REG_NUMBER_BASE, {26'd0, dir_rows[i].base});
        cur_base = dir_rows[i].base;
      end
      for (int j = 0; j < dir_rows[i].head.len(); j++)
        send_word(dir_rows[i].head[j], 1'b0, 1'b0, '0);
      send_word(dir_rows[i].tail, 1'b1, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part: sender idles lightly and receiver heavily, then the other
    // way round, then neither idles.
    for (int r = 0; r < 3; r++) begin
      for (int p = 0; p < 4; p++) begin
        k = r * 4 + p;
        drain_results();
        send_idle_pct = (r == 0) ? 15 : (r == 1) ? 60 : 0;
        recv_idle_pct = (r == 0) ? 60 : (r == 1) ? 15 : 0;
        write_register(REG_NUMBER_BASE, {26'd0, set_base[k]});
        write_register(REG_ALLOW_BINARY, {31'd0, set_binary[k]});
        if (r == 2 && p == 0) hold_request = 1'b1;
        words = 0;
        if (r == 1 && p == 0) begin
          // One string long enough for the offsets to saturate, sent while
          // the radix is decimal so that its digits are converted.
          text_q.delete();
          repeat (1025) text_q.push_back(blank_char());
          text_q.push_back(CH_ZERO + 8'd1);
          text_q.push_back(CH_ZERO + 8'd2);
          send_text(words);
          words = 0;
        end
        while (words < 75) begin
          build_text();
          send_text(words);
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
